// ----- sv/giou_pkg.sv -----
// Shared types and constants for the generalized IoU unit.
// Used by every module of the block; no dependencies of its own.
package giou_pkg;

  localparam int FIELD_W         = 16;
  localparam int GIOU_W          = 16;
  localparam int IOU_W           = 15;
  localparam int COORD_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 15;

  typedef struct packed {
    logic [FIELD_W-1:0] a_center_x;
    logic [FIELD_W-1:0] a_center_y;
    logic [FIELD_W-1:0] a_width;
    logic [FIELD_W-1:0] a_height;
    logic [FIELD_W-1:0] b_center_x;
    logic [FIELD_W-1:0] b_center_y;
    logic [FIELD_W-1:0] b_width;
    logic [FIELD_W-1:0] b_height;
  } giou_in_t;

  typedef struct packed {
    logic signed [GIOU_W-1:0] giou_value;
    logic        [IOU_W-1:0]  iou_value;
  } giou_out_t;

endpackage

// ----- sv/giou_front.sv -----
// Front end of the GIoU pipeline: corners, spans, areas, union and penalty numerator.
// Five registered stages with per-stage valid; depends on giou_pkg.
module giou_front
  import giou_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CW         = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W,
  parameter int DEN_W      = 2 * CW + 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  giou_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DEN_W-1:0] iou_num,
  output logic [DEN_W-1:0] iou_den,
  output logic [DEN_W-1:0] pen_num,
  output logic [DEN_W-1:0] pen_den
);

  localparam int CRN_W  = CW + 3;
  localparam int DIFF_W = CRN_W + 1;
  localparam int SPAN_W = CW + 2;

  logic [4:0] vld_r;
  logic [4:0] rdy;

  assign rdy[4]    = ~vld_r[4] | out_ready;
  assign rdy[3]    = ~vld_r[3] | rdy[4];
  assign rdy[2]    = ~vld_r[2] | rdy[3];
  assign rdy[1]    = ~vld_r[1] | rdy[2];
  assign rdy[0]    = ~vld_r[0] | rdy[1];
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
      if (rdy[3]) vld_r[3] <= vld_r[2];
      if (rdy[4]) vld_r[4] <= vld_r[3];
    end
  end

  // Stage 1: doubled-scale corners, clamped intersection and enclosing spans
  logic [CW-1:0] acx, acy, aw, ah, bcx, bcy, bw, bh;
  assign acx = in_data.a_center_x[CW-1:0];
  assign acy = in_data.a_center_y[CW-1:0];
  assign aw  = in_data.a_width[CW-1:0];
  assign ah  = in_data.a_height[CW-1:0];
  assign bcx = in_data.b_center_x[CW-1:0];
  assign bcy = in_data.b_center_y[CW-1:0];
  assign bw  = in_data.b_width[CW-1:0];
  assign bh  = in_data.b_height[CW-1:0];

  logic signed [CRN_W-1:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
  assign ax0 = $signed({2'b00, acx, 1'b0}) - $signed({3'b000, aw});
  assign ax1 = $signed({2'b00, acx, 1'b0}) + $signed({3'b000, aw});
  assign ay0 = $signed({2'b00, acy, 1'b0}) - $signed({3'b000, ah});
  assign ay1 = $signed({2'b00, acy, 1'b0}) + $signed({3'b000, ah});
  assign bx0 = $signed({2'b00, bcx, 1'b0}) - $signed({3'b000, bw});
  assign bx1 = $signed({2'b00, bcx, 1'b0}) + $signed({3'b000, bw});
  assign by0 = $signed({2'b00, bcy, 1'b0}) - $signed({3'b000, bh});
  assign by1 = $signed({2'b00, bcy, 1'b0}) + $signed({3'b000, bh});

  logic signed [CRN_W-1:0] ix_lo, ix_hi, iy_lo, iy_hi, ex_lo, ex_hi, ey_lo, ey_hi;
  assign ix_hi = (ax1 < bx1) ? ax1 : bx1;
  assign ix_lo = (ax0 > bx0) ? ax0 : bx0;
  assign iy_hi = (ay1 < by1) ? ay1 : by1;
  assign iy_lo = (ay0 > by0) ? ay0 : by0;
  assign ex_hi = (ax1 > bx1) ? ax1 : bx1;
  assign ex_lo = (ax0 < bx0) ? ax0 : bx0;
  assign ey_hi = (ay1 > by1) ? ay1 : by1;
  assign ey_lo = (ay0 < by0) ? ay0 : by0;

  logic signed [DIFF_W-1:0] iw_d, ih_d, ew_d, eh_d;
  assign iw_d = DIFF_W'(ix_hi) - DIFF_W'(ix_lo);
  assign ih_d = DIFF_W'(iy_hi) - DIFF_W'(iy_lo);
  assign ew_d = DIFF_W'(ex_hi) - DIFF_W'(ex_lo);
  assign eh_d = DIFF_W'(ey_hi) - DIFF_W'(ey_lo);

  logic [SPAN_W-1:0] iw_nxt, ih_nxt, ew_nxt, eh_nxt;
  assign iw_nxt = iw_d[DIFF_W-1] ? '0 : iw_d[SPAN_W-1:0];
  assign ih_nxt = ih_d[DIFF_W-1] ? '0 : ih_d[SPAN_W-1:0];
  assign ew_nxt = ew_d[DIFF_W-1] ? '0 : ew_d[SPAN_W-1:0];
  assign eh_nxt = eh_d[DIFF_W-1] ? '0 : eh_d[SPAN_W-1:0];

  logic [SPAN_W-1:0] iw_r, ih_r, ew_r, eh_r;
  logic [CW-1:0]     aw_r, ah_r, bw_r, bh_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      iw_r <= iw_nxt;
      ih_r <= ih_nxt;
      ew_r <= ew_nxt;
      eh_r <= eh_nxt;
      aw_r <= aw;
      ah_r <= ah;
      bw_r <= bw;
      bh_r <= bh;
    end
  end

  // Stage 2: products
  logic [DEN_W-1:0]  inter2_r, enc2_r;
  logic [2*CW-1:0]   pa_r, pb_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      inter2_r <= iw_r * ih_r;
      enc2_r   <= ew_r * eh_r;
      pa_r     <= aw_r * ah_r;
      pb_r     <= bw_r * bh_r;
    end
  end

  // Stage 3: summed box areas at four times the area scale
  logic [2*CW:0]    psum;
  logic [DEN_W-1:0] area_nxt;
  logic [DEN_W-1:0] area3_r, inter3_r, enc3_r;

  assign psum     = {1'b0, pa_r} + {1'b0, pb_r};
  assign area_nxt = DEN_W'({psum, 2'b00});

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      area3_r  <= area_nxt;
      inter3_r <= inter2_r;
      enc3_r   <= enc2_r;
    end
  end

  // Stage 4: union, clamped at zero
  logic [DEN_W-1:0] union_nxt;
  logic [DEN_W-1:0] union4_r, inter4_r, enc4_r;

  assign union_nxt = (area3_r >= inter3_r) ? (area3_r - inter3_r) : '0;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      union4_r <= union_nxt;
      inter4_r <= inter3_r;
      enc4_r   <= enc3_r;
    end
  end

  // Stage 5: enclosing penalty numerator
  logic [DEN_W-1:0] pen_nxt;
  logic [DEN_W-1:0] iou_num_r, iou_den_r, pen_num_r, pen_den_r;

  assign pen_nxt = (enc4_r > union4_r) ? (enc4_r - union4_r) : '0;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      iou_num_r <= inter4_r;
      iou_den_r <= union4_r;
      pen_num_r <= pen_nxt;
      pen_den_r <= enc4_r;
    end
  end

  assign iou_num = iou_num_r;
  assign iou_den = iou_den_r;
  assign pen_num = pen_num_r;
  assign pen_den = pen_den_r;

endmodule

// ----- sv/giou_div_cell.sv -----
// One cell of the divider chain: resolves one quotient bit of both the IoU and
// the penalty quotient and hands partial remainders on. Depends on giou_pkg.
module giou_div_cell
  import giou_pkg::*;
#(
  parameter int DEN_W = 2 * COORD_BITS_DEF + 4,
  parameter int QW    = FRAC_BITS_DEF + 1,
  parameter bit FIRST = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DEN_W:0]   iou_rem_in,
  input  logic [DEN_W-1:0] iou_den_in,
  input  logic [QW-1:0]    iou_q_in,
  input  logic [DEN_W:0]   pen_rem_in,
  input  logic [DEN_W-1:0] pen_den_in,
  input  logic [QW-1:0]    pen_q_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DEN_W:0]   iou_rem_out,
  output logic [DEN_W-1:0] iou_den_out,
  output logic [QW-1:0]    iou_q_out,
  output logic [DEN_W:0]   pen_rem_out,
  output logic [DEN_W-1:0] pen_den_out,
  output logic [QW-1:0]    pen_q_out
);

  logic valid_r;

  assign in_ready  = ~valid_r | out_ready;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // The leading cell weighs the unshifted numerator; later cells shift first
  logic [DEN_W:0] iou_sh, pen_sh;
  logic           iou_take, pen_take;
  logic [DEN_W:0] iou_rem_nxt, pen_rem_nxt;

  assign iou_sh   = FIRST ? iou_rem_in : {iou_rem_in[DEN_W-1:0], 1'b0};
  assign pen_sh   = FIRST ? pen_rem_in : {pen_rem_in[DEN_W-1:0], 1'b0};
  // A zero denominator yields a zero quotient
  assign iou_take = (iou_den_in != '0) && (iou_sh >= {1'b0, iou_den_in});
  assign pen_take = (pen_den_in != '0) && (pen_sh >= {1'b0, pen_den_in});
  assign iou_rem_nxt = iou_take ? (iou_sh - {1'b0, iou_den_in}) : iou_sh;
  assign pen_rem_nxt = pen_take ? (pen_sh - {1'b0, pen_den_in}) : pen_sh;

  logic [DEN_W:0]   iou_rem_r, pen_rem_r;
  logic [DEN_W-1:0] iou_den_r, pen_den_r;
  logic [QW-1:0]    iou_q_r, pen_q_r;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      iou_rem_r <= iou_rem_nxt;
      pen_rem_r <= pen_rem_nxt;
      iou_den_r <= iou_den_in;
      pen_den_r <= pen_den_in;
      iou_q_r   <= {iou_q_in[QW-2:0], iou_take};
      pen_q_r   <= {pen_q_in[QW-2:0], pen_take};
    end
  end

  assign iou_rem_out = iou_rem_r;
  assign pen_rem_out = pen_rem_r;
  assign iou_den_out = iou_den_r;
  assign pen_den_out = pen_den_r;
  assign iou_q_out   = iou_q_r;
  assign pen_q_out   = pen_q_r;

endmodule

// ----- sv/generalized_iou_two_boxes_unit.sv -----
// Generalized IoU of two axis-aligned boxes: front end, divider chain, output stage.
// Depends on giou_pkg, giou_front and giou_div_cell.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one box pair per item,
//   each box as center x, center y, width, height in unsigned Q8.8.
//   Result channel out_valid/out_ready/out_data carries one result per item:
//   GIoU as signed Q1.15 and the plain IoU as unsigned Q0.15, both saturated.
//   Items pass five front stages for corners, products, areas, union and
//   penalty, then one divider cell per quotient bit, then the output register.
//   Throughput is one item per cycle while out_ready stays high; each
//   divider cell settles one quotient bit for both quotients and passes
//   the item to its neighbor.
//   Every stage has its own valid bit, so a stalled receiver only holds the
//   items that sit behind a full stage; empty stages keep filling and
//   in_ready stays high until the chain is full back to the input.
//   Synchronous reset (rst_n low) empties all stages; no item is lost or
//   produced by reset beyond dropping those in flight.
module generalized_iou_two_boxes_unit
  import giou_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  giou_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output giou_out_t out_data
);

  localparam int CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int DEN_W = 2 * CW + 4;
  localparam int QW    = FRAC_BITS + 1;
  localparam int GX_W  = (FRAC_BITS + 2 > GIOU_W) ? FRAC_BITS + 2 : GIOU_W;
  localparam int IX_W  = (QW > IOU_W) ? QW : IOU_W;

  localparam logic signed [FRAC_BITS+1:0] SAT_MAX = (FRAC_BITS + 2)'((1 << FRAC_BITS) - 1);
  localparam logic signed [FRAC_BITS+1:0] SAT_MIN = -SAT_MAX;
  localparam logic        [QW-1:0]        IOU_MAX = QW'((1 << FRAC_BITS) - 1);

  logic             fe_valid, fe_ready;
  logic [DEN_W-1:0] fe_iou_num, fe_iou_den, fe_pen_num, fe_pen_den;

  giou_front #(
    .COORD_BITS (COORD_BITS),
    .CW         (CW),
    .DEN_W      (DEN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fe_valid),
    .out_ready (fe_ready),
    .iou_num   (fe_iou_num),
    .iou_den   (fe_iou_den),
    .pen_num   (fe_pen_num),
    .pen_den   (fe_pen_den)
  );

  // Divider chain links; index 0 is the front end, index QW the last cell
  logic             ch_valid [0:QW];
  logic             ch_ready [0:QW];
  logic [DEN_W:0]   ch_iou_rem [0:QW];
  logic [DEN_W-1:0] ch_iou_den [0:QW];
  logic [QW-1:0]    ch_iou_q [0:QW];
  logic [DEN_W:0]   ch_pen_rem [0:QW];
  logic [DEN_W-1:0] ch_pen_den [0:QW];
  logic [QW-1:0]    ch_pen_q [0:QW];

  assign ch_valid[0]   = fe_valid;
  assign fe_ready      = ch_ready[0];
  assign ch_iou_rem[0] = {1'b0, fe_iou_num};
  assign ch_iou_den[0] = fe_iou_den;
  assign ch_iou_q[0]   = '0;
  assign ch_pen_rem[0] = {1'b0, fe_pen_num};
  assign ch_pen_den[0] = fe_pen_den;
  assign ch_pen_q[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    giou_div_cell #(
      .DEN_W (DEN_W),
      .QW    (QW),
      .FIRST (k == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .in_valid    (ch_valid[k]),
      .in_ready    (ch_ready[k]),
      .iou_rem_in  (ch_iou_rem[k]),
      .iou_den_in  (ch_iou_den[k]),
      .iou_q_in    (ch_iou_q[k]),
      .pen_rem_in  (ch_pen_rem[k]),
      .pen_den_in  (ch_pen_den[k]),
      .pen_q_in    (ch_pen_q[k]),
      .out_valid   (ch_valid[k+1]),
      .out_ready   (ch_ready[k+1]),
      .iou_rem_out (ch_iou_rem[k+1]),
      .iou_den_out (ch_iou_den[k+1]),
      .iou_q_out   (ch_iou_q[k+1]),
      .pen_rem_out (ch_pen_rem[k+1]),
      .pen_den_out (ch_pen_den[k+1]),
      .pen_q_out   (ch_pen_q[k+1])
    );
  end

  // Output stage: GIoU = IoU - penalty, then saturate both values
  logic                    out_valid_r;
  giou_out_t               out_data_r;
  logic                    last_ready;
  logic signed [FRAC_BITS+1:0] diff;
  logic signed [FRAC_BITS+1:0] giou_sat;
  logic        [QW-1:0]        iou_sat;
  logic signed [GX_W-1:0]      giou_ext;
  logic        [IX_W-1:0]      iou_ext;
  giou_out_t                   out_data_nxt;

  assign last_ready   = ~out_valid_r | out_ready;
  assign ch_ready[QW] = last_ready;

  assign diff = $signed({1'b0, ch_iou_q[QW]}) - $signed({1'b0, ch_pen_q[QW]});

  always_comb begin
    priority if (diff > SAT_MAX) begin
      giou_sat = SAT_MAX;
    end else if (diff < SAT_MIN) begin
      giou_sat = SAT_MIN;
    end else begin
      giou_sat = diff;
    end
  end

  assign iou_sat  = (ch_iou_q[QW] > IOU_MAX) ? IOU_MAX : ch_iou_q[QW];
  assign giou_ext = GX_W'(giou_sat);
  assign iou_ext  = IX_W'(iou_sat);

  always_comb begin
    out_data_nxt.giou_value = giou_ext[GIOU_W-1:0];
    out_data_nxt.iou_value  = iou_ext[IOU_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_ready) begin
      out_valid_r <= ch_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
